/* sv/cave_pkg.sv */
// Shared constants and types for the cave smoothing pass.
package cave_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // register widths fixed by the register map
  localparam int CFG_W     = 11;
  localparam int THR_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_RAW  = $clog2(MAX_DIM + 1);
  localparam int DIM_W    = (DIM_RAW > CFG_W) ? DIM_RAW : CFG_W;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  // one spare bit so a saturated row count always lies past the last row
  localparam int ROW_W    = DIM_W + 1;
  localparam int CNT_W    = 4;

  localparam int WIN_COLS = 3;
  localparam int WIN_ROWS = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_SURVIVE_MIN = 2'd2,
    REG_BIRTH_MIN   = 2'd3
  } cfg_reg_t;

  // which neighbors of the centre cell lie inside the grid
  typedef struct packed {
    logic lft;
    logic rgt;
    logic up;
    logic dn;
  } cave_bnd_t;

endpackage

/* sv/cave_line_store.sv */
// Two row stores packed side by side in one memory, registered read with write bypass.
module cave_line_store
  import cave_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [1:0]       wr_data,
  input  logic [COL_W-1:0] rd_addr,
  output logic [1:0]       rd_data
);

  // bit 0 = upper (oldest) row, bit 1 = lower row
  logic [1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // one-cell rows read back the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/cave_window_cell.sv */
// One column of the 3x3 window; shifts its column to the next cell on each transaction.
module cave_window_cell
  import cave_pkg::*;
(
  input  logic                clk,
  input  logic                shift_en,
  input  logic                clear,
  input  logic [WIN_ROWS-1:0] col_in,
  output logic [WIN_ROWS-1:0] col_out
);

  logic [WIN_ROWS-1:0] col_bits;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_bits <= clear ? '0 : col_in;
    end
  end

  assign col_out = col_bits;

endmodule

/* sv/cave_rule.sv */
// Neighbor count over the window with edge masking, and the survive/birth decision.
module cave_rule
  import cave_pkg::*;
(
  input  logic [WIN_COLS*WIN_ROWS-1:0] win,
  input  cave_bnd_t                    bnd,
  input  logic [THR_W-1:0]             survive_min,
  input  logic [THR_W-1:0]             birth_min,
  output logic                         cell_out
);

  logic [CNT_W-1:0] cnt;

  // column 2 = left, 1 = centre, 0 = right; row bit 0 = up, bit 2 = down
  always_comb begin
    cnt = '0;
    if (bnd.lft) begin
      if (bnd.up) cnt = cnt + CNT_W'(win[6]);
      cnt = cnt + CNT_W'(win[7]);
      if (bnd.dn) cnt = cnt + CNT_W'(win[8]);
    end
    if (bnd.up) cnt = cnt + CNT_W'(win[3]);
    if (bnd.dn) cnt = cnt + CNT_W'(win[5]);
    if (bnd.rgt) begin
      if (bnd.up) cnt = cnt + CNT_W'(win[0]);
      cnt = cnt + CNT_W'(win[1]);
      if (bnd.dn) cnt = cnt + CNT_W'(win[2]);
    end
    if (win[4]) begin
      cell_out = (cnt >= survive_min);
    end else begin
      cell_out = (cnt >= birth_min);
    end
  end

endmodule

/* sv/cave_automaton_smoothing_pass_top.sv */
// Top level of the cave smoothing pass: position tracking, window chain, output stage.
//
// Cells arrive in raster order on the item channel (cell_value, is_pad), one
// transaction per cycle unless stalled; a pad item counts as a dead cell. The
// block holds two rows in a line store and a 3x3 window as a chain of three
// column cells. The result for a cell is formed when the input one row plus
// one cell later is accepted, then passes a rule stage and an output register
// before it appears on the result channel. After the grid, feed grid_width+1
// pad items to flush it; last_cell marks the final cell, after which the next
// item starts a new pass. Throughput is one cell per cycle unless stalled, set
// by the single-port-write line store and the window shift. A stalled result
// holds in the output register while one more result waits in the rule stage;
// only then is item_stall raised. Reset sets the registers to 64x64 with
// thresholds 4/5 and restarts the pass; the line store is not cleared, its
// stale entries only reach window positions outside the grid. Writes to
// grid_width or grid_height restart the pass; configure while idle.
module cave_automaton_smoothing_pass_top
  import cave_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 cell_value,
  input  logic                 is_pad,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 cell_next,
  output logic                 last_cell,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [THR_W-1:0] survive_min;
  logic [THR_W-1:0] birth_min;

  logic [COL_W-1:0] col_pos, col_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;
  logic             restart, restart_next;

  logic             s1_valid;
  cave_bnd_t        s1_bnd;

  logic [DIM_W-1:0] eff_w, eff_h, col_inc;
  logic [ROW_W-1:0] rc;
  logic [COL_W-1:0] cc;
  logic             have, last, dim_write, item_accept, out_free, cur, rule_out;
  cave_bnd_t        bnd;
  logic [1:0]       line_rd;
  logic [WIN_ROWS-1:0] col_new;
  logic [WIN_ROWS-1:0] win [WIN_COLS];
  logic [WIN_COLS*WIN_ROWS-1:0] win_flat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(64);
      grid_height <= CFG_W'(64);
      survive_min <= THR_W'(4);
      birth_min   <= THR_W'(5);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_SURVIVE_MIN: survive_min <= cfg_data[THR_W-1:0];
        REG_BIRTH_MIN:   birth_min   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign dim_write = cfg_write && ((cfg_reg_t'(cfg_index) == REG_GRID_WIDTH) ||
                                   (cfg_reg_t'(cfg_index) == REG_GRID_HEIGHT));

  // zero reads as one, oversize as the maximum
  always_comb begin
    if (grid_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (DIM_W'(grid_width) > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = DIM_W'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (DIM_W'(grid_height) > DIM_W'(MAX_HEIGHT)) begin
      eff_h = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = DIM_W'(grid_height);
    end
  end

  assign out_free    = !result_valid || !result_stall;
  assign item_stall  = s1_valid && !out_free;
  assign item_accept = item_valid && !item_stall;
  assign cur         = cell_value & ~is_pad;

  // which cell, if any, completes its window with this item
  always_comb begin
    if (col_pos != '0) begin
      have = (row_pos >= ROW_W'(1));
      rc   = row_pos - ROW_W'(1);
      cc   = col_pos - COL_W'(1);
    end else begin
      have = (row_pos >= ROW_W'(2));
      rc   = row_pos - ROW_W'(2);
      cc   = COL_W'(eff_w - DIM_W'(1));
    end
    have    = have && (rc < ROW_W'(eff_h));
    bnd.lft = (cc != '0);
    bnd.rgt = ((DIM_W'(cc) + DIM_W'(1)) < eff_w);
    bnd.up  = (rc != '0);
    bnd.dn  = ((rc + ROW_W'(1)) < ROW_W'(eff_h));
    last    = !bnd.rgt && !bnd.dn;
    col_inc = DIM_W'(col_pos) + DIM_W'(1);
  end

  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    restart_next = restart;
    if (dim_write) begin
      col_pos_next = '0;
      row_pos_next = '0;
      restart_next = 1'b1;
    end else if (item_accept) begin
      restart_next = 1'b0;
      if (have && last) begin
        col_pos_next = '0;
        row_pos_next = '0;
        restart_next = 1'b1;
      end else if (col_inc >= eff_w) begin
        col_pos_next = '0;
        row_pos_next = (row_pos == '1) ? row_pos : row_pos + ROW_W'(1);
      end else begin
        col_pos_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      restart <= 1'b1;
    end else begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
      restart <= restart_next;
    end
  end

  // read side runs one column ahead so the data is ready when the item arrives
  cave_line_store u_line_store (
    .clk     (clk),
    .wr_en   (item_accept),
    .wr_addr (col_pos),
    .wr_data ({cur, line_rd[1]}),
    .rd_addr (col_pos_next),
    .rd_data (line_rd)
  );

  assign col_new = {cur, line_rd};

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      cave_window_cell u_cell (
        .clk      (clk),
        .shift_en (item_accept),
        .clear    (1'b0),
        .col_in   (col_new),
        .col_out  (win[k])
      );
    end else begin : g_tail
      cave_window_cell u_cell (
        .clk      (clk),
        .shift_en (item_accept),
        .clear    (restart),
        .col_in   (win[k-1]),
        .col_out  (win[k])
      );
    end
    assign win_flat[k*WIN_ROWS +: WIN_ROWS] = win[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= have;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_bnd <= bnd;
    end
  end

  cave_rule u_rule (
    .win         (win_flat),
    .bnd         (s1_bnd),
    .survive_min (survive_min),
    .birth_min   (birth_min),
    .cell_out    (rule_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      cell_next <= rule_out;
      last_cell <= !s1_bnd.rgt && !s1_bnd.dn;
    end
  end

  // column pointer stays inside the row in use
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(col_pos) < eff_w)
    else $error("column position past row width");

  // the final cell of the grid sends the position back to the origin
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    item_accept && have && last && !dim_write |=> (col_pos == '0) && (row_pos == '0) && restart)
    else $error("pass did not restart after final cell");

  // a new result only comes from the rule stage
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result without a pending window");

endmodule
